// ===== hdl/percent_url_codec_macros.svh =====
// Assertion macros for the percent URL codec.
// Used by the checker module; no other dependencies.
`ifndef PERCENT_URL_CODEC_MACROS_SVH
`define PERCENT_URL_CODEC_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define PUC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PUC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/puc_pkg.sv =====
// Package for the percent URL codec: types, codes and byte class functions.
// No dependencies.
`default_nettype none

package puc_pkg;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic REG_DECODE_MODE = 1'b0;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_t;

  typedef struct packed {
    logic decode_mode;
    logic clear;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } res_t;

  function automatic logic is_unreserved(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                      8'h2D, 8'h5F, 8'h2E, 8'h7E});
  endfunction

  // {is_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h00;
    if (b inside {[8'h30:8'h39]}) begin
      v = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b1, b[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/puc_ifs.sv =====
// Valid/ready channel interfaces for the percent URL codec.
// Input channel carries one text byte, output channel one produced byte.
`default_nettype none

interface puc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface puc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/percent_url_codec.sv =====
// Percent URL codec. Takes one text byte per item on the input channel and
// gives encoded or decoded bytes on the output channel, one per cycle while
// the output is ready. An item yielding one or no byte can enter every cycle
// while the output keeps up; an escaped byte in encode mode (three bytes)
// holds off the next item while the one-byte-wide output register sends its
// bytes. An item passes the input and result registers before its first
// output byte. decode_mode sits at APB address 0 and may only be written
// while the codec is idle; a write also clears any partial escape. Depends on
// puc_pkg, the channel interfaces, puc_cfg, puc_core and puc_out.
`default_nettype none

module percent_url_codec (
  input  wire logic                         clk,
  input  wire logic                         rst,
  puc_in_if.sink                            items,
  puc_out_if.source                         results,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [puc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [puc_pkg::APB_DW-1:0]   pwdata,
  output logic      [puc_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  puc_pkg::cfg_t cfg;
  puc_pkg::res_t res;
  logic          can_load;
  logic          load;

  puc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  puc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .items    (items),
    .can_load (can_load),
    .load     (load),
    .res      (res)
  );

  puc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .res      (res),
    .can_load (can_load),
    .results  (results)
  );

endmodule

`default_nettype wire

// ===== hdl/puc_cfg.sv =====
// APB register block for the percent URL codec: holds decode_mode.
// Depends on puc_pkg.
`default_nettype none

module puc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [puc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [puc_pkg::APB_DW-1:0]   pwdata,
  output logic      [puc_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output puc_pkg::cfg_t                     cfg
);

  logic decode_mode;
  logic wr_mode;

  assign pready  = 1'b1;
  assign wr_mode = psel && penable && pwrite && pready &&
                   (paddr[2] == puc_pkg::REG_DECODE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= puc_pkg::MODE_ENCODE;
    end else if (wr_mode) begin
      decode_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == puc_pkg::REG_DECODE_MODE) begin
      prdata[0] = decode_mode;
    end
  end

  assign cfg.decode_mode = decode_mode;
  assign cfg.clear       = wr_mode;

endmodule

`default_nettype wire

// ===== hdl/puc_core.sv =====
// Input register and single-pass encode/decode logic with escape state.
// Depends on puc_pkg.
`default_nettype none

module puc_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire puc_pkg::cfg_t cfg,
  puc_in_if.sink             items,
  input  wire logic          can_load,
  output logic               load,
  output puc_pkg::res_t      res
);

  logic             item_vld;
  logic [7:0]       item_byte;
  logic             item_end;

  puc_pkg::phase_t  phase, phase_next;
  logic [3:0]       hi_nib, hi_nib_next;
  logic             first_hex, first_hex_next;

  logic [4:0]       hv;

  assign load        = item_vld && can_load;
  assign items.ready = !item_vld || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (items.ready) begin
      item_vld <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      item_byte <= items.in_byte;
      item_end  <= items.stream_end;
    end
  end

  assign hv = puc_pkg::hex_value(item_byte);

  always_comb begin
    res            = '0;
    phase_next     = puc_pkg::PH_IDLE;
    hi_nib_next    = 4'h0;
    first_hex_next = 1'b0;
    if (cfg.decode_mode == puc_pkg::MODE_ENCODE) begin
      if (puc_pkg::is_unreserved(item_byte)) begin
        res.cnt = 2'd1;
        res.b0  = item_byte;
      end else begin
        res.cnt = 2'd3;
        res.b0  = puc_pkg::PCT_CHAR;
        res.b1  = puc_pkg::hex_upper(item_byte[7:4]);
        res.b2  = puc_pkg::hex_upper(item_byte[3:0]);
      end
    end else begin
      case (phase)
        puc_pkg::PH_PCT: begin
          phase_next     = puc_pkg::PH_DIG;
          hi_nib_next    = hv[3:0];
          first_hex_next = hv[4];
        end
        puc_pkg::PH_DIG: begin
          if (first_hex && hv[4]) begin
            res.cnt = 2'd1;
            res.b0  = {hi_nib, hv[3:0]};
          end
        end
        default: begin
          if (item_byte == puc_pkg::PCT_CHAR) begin
            phase_next = puc_pkg::PH_PCT;
          end else begin
            res.cnt = 2'd1;
            res.b0  = item_byte;
          end
        end
      endcase
      if (item_end) begin
        phase_next     = puc_pkg::PH_IDLE;
        hi_nib_next    = 4'h0;
        first_hex_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      phase     <= puc_pkg::PH_IDLE;
      hi_nib    <= 4'h0;
      first_hex <= 1'b0;
    end else if (load) begin
      phase     <= phase_next;
      hi_nib    <= hi_nib_next;
      first_hex <= first_hex_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/puc_out.sv =====
// Result register: holds up to three bytes of one item, one sent per ready cycle.
// Depends on puc_pkg.
`default_nettype none

module puc_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire puc_pkg::res_t res,
  output logic               can_load,
  puc_out_if.source          results
);

  logic [1:0] remain;
  logic [7:0] b0, b1, b2;
  logic       pop;

  assign pop      = results.valid && results.ready;
  assign can_load = (remain == 2'd0) || ((remain == 2'd1) && results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 2'd0;
    end else if (load) begin
      remain <= res.cnt;
    end else if (pop) begin
      remain <= remain - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b0 <= res.b0;
      b1 <= res.b1;
      b2 <= res.b2;
    end else if (pop) begin
      b0 <= b1;
      b1 <= b2;
    end
  end

  assign results.valid    = (remain != 2'd0);
  assign results.out_byte = b0;
  assign results.run_last = (remain == 2'd1);

endmodule

`default_nettype wire

// ===== hdl/puc_checker.sv =====
// Port-level checks for the percent URL codec, bound to the top level.
// Depends on puc_pkg and percent_url_codec_macros.svh.
`default_nettype none
`include "percent_url_codec_macros.svh"

module puc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [7:0]                 out_byte,
  input wire logic                       run_last,
  input wire logic [puc_pkg::APB_DW-1:0] prdata,
  input wire logic                       pready
);

  `PUC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last), "stalled item changed")
  `PUC_ASSERT(a_run_continues, clk, rst, out_valid && !run_last && out_ready |=> out_valid, "item run broken before its last byte")
  `PUC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")
  `PUC_ASSERT(a_apb_read, clk, rst, pready && (prdata[puc_pkg::APB_DW-1:1] == '0), "bad APB response")

endmodule

bind percent_url_codec puc_checker u_puc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_byte  (results.out_byte),
  .run_last  (results.run_last),
  .prdata    (prdata),
  .pready    (pready)
);

`default_nettype wire

// ===== tb/percent_url_codec_checker.sv =====
// Checker for the percent URL codec: watches the item, result and APB channels,
// predicts every output byte and compares it with what the codec gives.
// Depends on puc_pkg and the channel interfaces in puc_ifs.

module percent_url_codec_checker (
  input  logic                        clk,
  input  logic                        rst,
  puc_in_if                           items,
  puc_out_if                          results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [puc_pkg::APB_AW-1:0]  paddr,
  input  logic [puc_pkg::APB_DW-1:0]  pwdata,
  output int                          fail_count,
  output int                          pending,
  output int                          items_seen,
  output int                          bytes_seen
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } codec_byte_t;

  codec_byte_t expected_bytes[$];

  logic            decode_on;
  puc_pkg::phase_t esc_phase;
  logic [3:0]      esc_high;
  logic            esc_first_hex;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'h00;
  endfunction

  function automatic logic passes_plain(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == "-" || c == "_" || c == "." || c == "~";
  endfunction

  function automatic logic [7:0] upper_hex_char(input logic [3:0] v);
    return (v <= 4'd9) ? "0" + {4'h0, v} : "A" + {4'h0, v} - 8'd10;
  endfunction

  function void clear_escape();
    esc_phase     = puc_pkg::PH_IDLE;
    esc_high      = 4'h0;
    esc_first_hex = 1'b0;
  endfunction

  function void expect_byte(input logic [7:0] b, input logic last);
    codec_byte_t e;
    e.out_byte = b;
    e.run_last = last;
    expected_bytes = {expected_bytes, e};
  endfunction

  function void predict_codec_step(input logic [7:0] b, input logic fin);
    logic [4:0] nib;
    nib = hex_digit_value(b);
    if (decode_on == puc_pkg::MODE_ENCODE) begin
      if (passes_plain(b)) begin
        expect_byte(b, 1'b1);
      end else begin
        expect_byte(puc_pkg::PCT_CHAR, 1'b0);
        expect_byte(upper_hex_char(b[7:4]), 1'b0);
        expect_byte(upper_hex_char(b[3:0]), 1'b1);
      end
      clear_escape();
    end else begin
      case (esc_phase)
        puc_pkg::PH_PCT: begin
          esc_first_hex = nib[4];
          esc_high      = nib[3:0];
          esc_phase     = puc_pkg::PH_DIG;
        end
        puc_pkg::PH_DIG: begin
          if (esc_first_hex && nib[4]) expect_byte({esc_high, nib[3:0]}, 1'b1);
          clear_escape();
        end
        default: begin
          if (b == puc_pkg::PCT_CHAR) begin
            esc_phase     = puc_pkg::PH_PCT;
            esc_high      = 4'h0;
            esc_first_hex = 1'b0;
          end else begin
            expect_byte(b, 1'b1);
            clear_escape();
          end
        end
      endcase
    end
    if (fin) clear_escape();
  endfunction

  function void report_fault(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    codec_byte_t want;
    if (rst) begin
      decode_on = puc_pkg::MODE_ENCODE;
      clear_escape();
      expected_bytes.delete();
      fail_count = 0;
      pending    = 0;
      items_seen = 0;
      bytes_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          (paddr >> 2) == puc_pkg::REG_DECODE_MODE) begin
        decode_on = pwdata[0];
        clear_escape();
      end
      if (items.valid && items.ready) begin
        items_seen++;
        predict_codec_step(items.in_byte, items.stream_end);
      end
      if (results.valid && results.ready) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          report_fault($sformatf("unexpected byte %02h last %0b",
                                 results.out_byte, results.run_last));
        end else begin
          want = expected_bytes.pop_front();
          if (want.out_byte !== results.out_byte || want.run_last !== results.run_last)
            report_fault($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                   want.out_byte, want.run_last,
                                   results.out_byte, results.run_last));
        end
      end
      pending = expected_bytes.size();
    end
  end

endmodule

// ===== tb/percent_url_codec_tb.sv =====
// Top of the percent URL codec testbench: clock, reset, APB writes, item stimulus
// and output back-pressure; the checker module does the comparing.
// Depends on puc_pkg, puc_ifs, percent_url_codec and percent_url_codec_checker.

module percent_url_codec_tb;

  localparam int unsigned SPARE_REG_IDX = 1;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [puc_pkg::APB_AW-1:0] paddr;
  logic [puc_pkg::APB_DW-1:0] pwdata;
  logic [puc_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  int   fail_count;
  int   pending;
  int   items_seen;
  int   bytes_seen;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  logic hold_go        = 1'b0;
  logic hold_done      = 1'b0;
  int   cycle_count    = 0;

  puc_in_if  items_ch();
  puc_out_if results_ch();

  percent_url_codec dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  percent_url_codec_checker bytes_check (
    .clk        (clk),
    .rst        (rst),
    .items      (items_ch),
    .results    (results_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .items_seen (items_seen),
    .bytes_seen (bytes_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.in_byte    <= b;
    items_ch.stream_end <= fin;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic settle();
    @(negedge clk);
    items_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [puc_pkg::APB_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= puc_pkg::APB_AW'(idx * 4);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_mode(input logic m);
    settle();
    write_reg(puc_pkg::REG_DECODE_MODE, m);
  endtask

  function automatic logic [7:0] pick_hex_char();
    int k;
    k = $urandom_range(21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("A" + k - 10);
    return 8'("a" + k - 16);
  endfunction

  task automatic random_encode_item();
    logic [7:0] b;
    b = ($urandom_range(2) == 0) ? 8'("a" + $urandom_range(25)) : 8'($urandom_range(255));
    send_byte(b, $urandom_range(7) == 0);
  endtask

  task automatic random_decode_run(output int n);
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      send_byte(puc_pkg::PCT_CHAR, 1'b0);
      send_byte(pick_hex_char(), 1'b0);
      send_byte(pick_hex_char(), $urandom_range(7) == 0);
      n = 3;
    end else if (kind < 78) begin
      send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      n = 1;
    end else if (kind < 90) begin
      // escape with arbitrary, mostly non-hex bytes
      send_byte(puc_pkg::PCT_CHAR, 1'b0);
      send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      n = 3;
    end else begin
      // escape cut short by end of stream
      if ($urandom_range(1) == 0) begin
        send_byte(puc_pkg::PCT_CHAR, 1'b1);
        n = 1;
      end else begin
        send_byte(puc_pkg::PCT_CHAR, 1'b0);
        send_byte(pick_hex_char(), 1'b1);
        n = 2;
      end
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input logic with_hold);
    int sent;
    int n;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    set_mode(puc_pkg::MODE_ENCODE);
    if (with_hold) begin
      @(posedge clk);
      hold_go = 1'b1;
    end
    repeat (with_hold ? 16 : 6) random_encode_item();
    set_mode(puc_pkg::MODE_DECODE);
    sent = 0;
    while (sent < 10) begin
      random_decode_run(n);
      sent += n;
    end
  endtask

  initial begin
    items_ch.valid      = 1'b0;
    items_ch.in_byte    = 8'h00;
    items_ch.stream_end = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no register there, must not change the mode
    write_reg(SPARE_REG_IDX, '1);
    set_mode(puc_pkg::MODE_ENCODE);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("Az9-_.~% ", 1'b1);

    set_mode(puc_pkg::MODE_DECODE);
    send_text("%4f", 1'b0);
    send_text("%G1", 1'b0);
    send_text("%4%", 1'b0);
    send_text("%a", 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("%", 1'b0);
    // mode write drops the open escape
    set_mode(puc_pkg::MODE_DECODE);
    send_text("1", 1'b0);

    run_phase(0, 0, 1'b1);
    run_phase(74, 0, 1'b0);
    run_phase(0, 74, 1'b0);
    run_phase(7, 7, 1'b0);
    settle();

    $display("Covered %0d input items and %0d output bytes in encode and decode mode,",
             items_seen, bytes_seen);
    $display("with good, bad and cut escapes, four handshake mixes and a long output hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/puc_pkg.sv
hdl/puc_ifs.sv
hdl/puc_cfg.sv
hdl/puc_core.sv
hdl/puc_out.sv
hdl/percent_url_codec.sv
hdl/puc_checker.sv
tb/percent_url_codec_checker.sv
tb/percent_url_codec_tb.sv
